/* design/descending_priority_queue_macros.svh */
// assertion macros used by the queue top level
// expects clock and reset to be visible where a macro is used
`ifndef DESCENDING_PRIORITY_QUEUE_MACROS_SVH
`define DESCENDING_PRIORITY_QUEUE_MACROS_SVH

// property checked on every edge outside reset
`define DPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent on one edge, consequent on the next
`define DPQ_ASSERT_NEXT(lbl, cause, effect, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

/* design/dpq_pkg.sv */
// shared types and codes for the descending priority queue
// no dependencies
`timescale 1ns / 1ps

package dpq_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // per-cell write controls
   typedef struct packed {
      logic               load;
      logic               shift;
      logic signed [31:0] data;
   } cell_ctl_type;

   // running maximum handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic signed [31:0] value;
   } best_type;

endpackage

/* design/descending_priority_queue.sv */
// Bounded max-priority queue of signed 32-bit values held in insertion order in a row of
// CAPACITY cells. Commands: insert, remove maximum (earliest of equal maxima), clear; each
// returns one response with status, removed value and entry count. Each cell keeps the
// maximum of itself and all later cells, and that running maximum moves one cell per cycle
// toward the head. After an insert or a successful remove the queue therefore stays busy
// until a settle counter, loaded with the entry count after the command, has run down to
// zero; clear, no-op, overflow and underflow leave the settle counter at zero. The
// response is registered; a response that waits holds off the next request, which is
// accepted at the earliest in the cycle in which that response is taken.
// Depends on dpq_pkg, dpq_cell and descending_priority_queue_macros.svh.
`timescale 1ns / 1ps
`include "descending_priority_queue_macros.svh"

module descending_priority_queue
   import dpq_pkg::*;
#(
   parameter int CAPACITY = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic [3:0]         rsp_entries_held
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = $clog2(CAPACITY);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   settle_ff, settle_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic signed [31:0] removed_ff, removed_in;
   logic [3:0]         held_ff, held_in;

   logic               accept;
   cmd_type            cmd;
   logic               full, empty;

   cell_ctl_type       ctl     [CAPACITY];
   logic               valid_v [CAPACITY];
   logic signed [31:0] val_v   [CAPACITY+1];
   best_type           best_v  [CAPACITY+1];
   logic [POS_W-1:0]   pos_v   [CAPACITY+1];

   assign cmd       = cmd_type'(req_command);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign req_ready = (settle_ff == '0) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // end of the row: nothing beyond the last cell
   assign val_v[CAPACITY]  = '0;
   assign best_v[CAPACITY] = '{valid: 1'b0, value: '0};
   assign pos_v[CAPACITY]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid_v[i]   = (CNT_W'(i) < count_ff);
      assign ctl[i].load  = accept && (cmd == CMD_INSERT) && !full && (count_ff == CNT_W'(i));
      assign ctl[i].shift = accept && (cmd == CMD_REMOVE) && !empty
                            && (CNT_W'(i) >= CNT_W'(pos_v[0]));
      assign ctl[i].data  = req_value;

      dpq_cell #(
         .POS_W (POS_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl[i]),
         .here_valid (valid_v[i]),
         .here_pos   (POS_W'(i)),
         .nb_value   (val_v[i+1]),
         .nb_best    (best_v[i+1]),
         .nb_pos     (pos_v[i+1]),
         .value      (val_v[i]),
         .best       (best_v[i]),
         .best_pos   (pos_v[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      settle_in    = (settle_ff != '0) ? settle_ff - CNT_W'(1) : settle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      removed_in   = removed_ff;
      held_in      = held_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_DONE;
         removed_in   = '0;
         unique case (cmd)
            CMD_INSERT: begin
               if (full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  count_in  = count_ff + CNT_W'(1);
                  settle_in = count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (empty) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  removed_in = best_v[0].value;
                  count_in   = count_ff - CNT_W'(1);
                  settle_in  = count_ff - CNT_W'(1);
               end
            end
            CMD_CLEAR: begin
               count_in  = '0;
               settle_in = '0;
            end
            CMD_NOP: begin
            end
         endcase
         held_in = 4'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      removed_ff <= removed_in;
      held_ff    <= held_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_entries_held  = held_ff;

   `DPQ_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")
   `DPQ_ASSERT(a_settle_bound, settle_ff <= count_ff, "settle wait longer than entry count")
   `DPQ_ASSERT_NEXT(a_rsp_follows, accept, rsp_valid_ff, "no response after accepted transaction")
   `DPQ_ASSERT_NEXT(a_remove_shrinks, accept && cmd == CMD_REMOVE && !empty, count_ff == $past(count_ff) - CNT_W'(1), "remove did not shrink count")
   `DPQ_ASSERT(a_underflow_zero, !(rsp_valid_ff && status_ff == STATUS_UNDERFLOW) || (removed_ff == '0), "underflow response carries a value")

endmodule

/* design/dpq_cell.sv */
// one storage cell: holds an entry and the maximum of itself and all later entries
// depends on dpq_pkg
`timescale 1ns / 1ps

module dpq_cell
   import dpq_pkg::*;
#(
   parameter int POS_W = 3
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               here_valid,
   input  logic [POS_W-1:0]   here_pos,
   input  logic signed [31:0] nb_value,
   input  best_type           nb_best,
   input  logic [POS_W-1:0]   nb_pos,
   output logic signed [31:0] value,
   output best_type           best,
   output logic [POS_W-1:0]   best_pos
);

   logic signed [31:0] value_ff, value_in;
   best_type           best_ff, best_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = ctl.data;
      end else if (ctl.shift) begin
         value_in = nb_value;
      end
   end

   // ties keep this cell, so the earliest entry wins
   always_comb begin
      if (!here_valid) begin
         best_in = '{valid: 1'b0, value: '0};
         pos_in  = '0;
      end else if (!nb_best.valid || value_ff >= nb_best.value) begin
         best_in = '{valid: 1'b1, value: value_ff};
         pos_in  = here_pos;
      end else begin
         best_in = nb_best;
         pos_in  = nb_pos;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      best_ff  <= best_in;
      pos_ff   <= pos_in;
   end

   // an empty cell never offers a maximum, even while its register is stale
   assign value    = value_ff;
   assign best     = '{valid: best_ff.valid && here_valid, value: best_ff.value};
   assign best_pos = pos_ff;

endmodule

/* tb/tb_descending_priority_queue.sv */
// self-checking testbench for descending_priority_queue: directed and random command traffic
// with random idling on both channels, every response checked against a behavioral queue
// depends on dpq_pkg and the descending_priority_queue rtl
`timescale 1ns / 1ps

module tb_descending_priority_queue
   import dpq_pkg::*;
;

   localparam int CAPACITY     = 8;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_LIMIT   = 2000;

   typedef struct {
      cmd_type            cmd;
      logic signed [31:0] value;
   } queue_cmd_type;

   typedef struct {
      status_type         status;
      logic signed [31:0] removed;
      logic [3:0]         held;
   } queue_rsp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_command;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_removed_value;
   logic [3:0]         rsp_entries_held;

   descending_priority_queue #(.CAPACITY(CAPACITY)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entries_held  (rsp_entries_held)
   );

   // behavioral copy of the queue contents
   logic signed [31:0] held_values [CAPACITY];
   int                 held_count;

   queue_cmd_type  pending_cmds[$];
   queue_rsp_type  expected_responses[$];

   int total_items;
   int accepted_items;
   int checked_rsps;
   int error_count;
   int idle_cycles;
   int send_gap;
   int send_burst;
   int stall_left;
   int rsp_burst;
   int n_insert, n_remove, n_clear, n_nop, n_overflow, n_underflow;
   logic          req_taken;
   queue_cmd_type next_cmd;
   queue_cmd_type seen_cmd;
   queue_rsp_type want;

   function automatic queue_rsp_type apply_queue_command(queue_cmd_type c);
      queue_rsp_type r;
      int            best_pos;
      r.status  = STATUS_DONE;
      r.removed = '0;
      case (c.cmd)
         CMD_INSERT: begin
            if (held_count >= CAPACITY) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               held_values[held_count] = c.value;
               held_count++;
            end
         end
         CMD_REMOVE: begin
            if (held_count == 0) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               best_pos = 0;
               // strict compare keeps the earliest of equal maxima
               for (int i = 1; i < held_count; i++)
                  if (held_values[i] > held_values[best_pos])
                     best_pos = i;
               r.removed = held_values[best_pos];
               for (int i = best_pos; i < held_count - 1; i++)
                  held_values[i] = held_values[i + 1];
               held_count--;
            end
         end
         CMD_CLEAR: held_count = 0;
         default: ;
      endcase
      r.held = held_count[3:0];
      return r;
   endfunction

   // mostly short gaps, a few long ones, and stretches with none
   function automatic int next_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom;
      if (r < 75) return $signed($urandom_range(0, 8)) - 4;
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh0;
            default: return -32'sh1;
         endcase
      end
      return $signed($urandom_range(0, 1000)) * (($urandom_range(0, 1) == 1) ? 1 : -1);
   endfunction

   task automatic add_item(cmd_type cmd, logic signed [31:0] value);
      queue_cmd_type c;
      c.cmd   = cmd;
      c.value = value;
      pending_cmds.push_back(c);
      total_items++;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // transaction driver, changes inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until accepted
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
         next_cmd = pending_cmds.pop_front();
         req_command <= next_cmd.cmd;
         req_value   <= next_cmd.value;
         req_valid   <= 1'b1;
         send_gap = next_gap(send_burst);
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 2) == 0)
            stall_left = next_gap(rsp_burst);
      end
   end

   // monitor and checker, samples on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            seen_cmd.cmd   = cmd_type'(req_command);
            seen_cmd.value = req_value;
            case (seen_cmd.cmd)
               CMD_INSERT: n_insert++;
               CMD_REMOVE: n_remove++;
               CMD_CLEAR:  n_clear++;
               default:    n_nop++;
            endcase
            expected_responses.push_back(apply_queue_command(seen_cmd));
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no transaction outstanding: status %0d value %0d held %0d",
                      rsp_status, rsp_removed_value, rsp_entries_held);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               checked_rsps++;
               if (want.status == STATUS_OVERFLOW) n_overflow++;
               if (want.status == STATUS_UNDERFLOW) n_underflow++;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_removed_value !== want.removed) begin
                  $error("removed_value: expected %0d, got %0d", want.removed,
                         rsp_removed_value);
                  error_count++;
               end
               if (rsp_entries_held !== want.held) begin
                  $error("entries_held: expected %0d, got %0d", want.held, rsp_entries_held);
                  error_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", IDLE_LIMIT);
            $display("tb_descending_priority_queue: done, errors");
            $finish;
         end
      end
   end

   initial begin
      bit filling;
      int phase_left;
      int r;
      cmd_type cmd;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_NOP;
      req_value   = '0;
      rsp_ready   = 1'b0;
      held_count  = 0;
      foreach (held_values[i]) held_values[i] = '0;

      // empty queue corners, fill past full, drain past empty
      add_item(CMD_REMOVE, 32'sh0);
      add_item(CMD_CLEAR, 32'sh5a5a5a5a);
      add_item(CMD_NOP, -32'sh1);
      add_item(CMD_INSERT, 32'sh7fffffff);
      add_item(CMD_INSERT, 32'sh80000000);
      add_item(CMD_INSERT, 32'sh0);
      add_item(CMD_INSERT, -32'sh1);
      add_item(CMD_INSERT, 32'sh7fffffff);
      add_item(CMD_INSERT, 32'sh1);
      add_item(CMD_INSERT, 32'sh5);
      add_item(CMD_INSERT, 32'sh5);
      add_item(CMD_INSERT, 32'sh2a);
      add_item(CMD_NOP, 32'sh80000000);
      for (int i = 0; i < CAPACITY; i++)
         add_item(CMD_REMOVE, 32'sh7fffffff);
      add_item(CMD_REMOVE, 32'sh0);
      add_item(CMD_INSERT, 32'sh3);
      add_item(CMD_CLEAR, 32'sh0);

      // random fill and drain phases so full and empty are hit often
      phase_left = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (phase_left == 0) begin
            filling    = $urandom_range(0, 1);
            phase_left = $urandom_range(4, 20);
         end
         phase_left--;
         r = $urandom_range(0, 99);
         if (r < 3)       cmd = CMD_CLEAR;
         else if (r < 6)  cmd = CMD_NOP;
         else if (r < 84) cmd = filling ? CMD_INSERT : CMD_REMOVE;
         else             cmd = filling ? CMD_REMOVE : CMD_INSERT;
         add_item(cmd, pick_value());
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_items == total_items);
      wait (expected_responses.size() == 0);
      repeat (CAPACITY + 4) @(posedge clock);

      $display("%0d transactions checked: %0d insert, %0d remove, %0d clear, %0d no-op",
               checked_rsps, n_insert, n_remove, n_clear, n_nop);
      $display("%0d overflow and %0d underflow responses seen", n_overflow, n_underflow);
      if (error_count == 0) begin
         $display("tb_descending_priority_queue: done, clean");
      end else begin
         $display("tb_descending_priority_queue: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/dpq_pkg.sv
design/dpq_cell.sv
design/descending_priority_queue.sv
tb/tb_descending_priority_queue.sv
